// ----- src/ffsa_pkg.sv -----
package ffsa_pkg;

  localparam int unsigned LEN_W  = 21;
  localparam int unsigned ADDR_W = 20;

  localparam int unsigned DEF_POOL_BYTES   = 1024 * 1024;
  localparam int unsigned DEF_HEADER_BYTES = 24;
  localparam int unsigned DEF_MAX_SEGMENTS = 64;

  // Stream payload widths, rounded up to whole bytes.
  localparam int unsigned IN_TDATA_W  = ((LEN_W + ADDR_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((2 + ADDR_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_ZERO    = 2'd1,
    STAT_NOFIT   = 2'd2,
    STAT_BADFREE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_SHUP,
    ST_SPLIT,
    ST_FNEXT,
    ST_FMERGE,
    ST_SHDN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic             used;
    logic [LEN_W-1:0] len;
  } seg_t;

  typedef struct packed {
    logic              action;
    logic [LEN_W-1:0]  size;
    logic [ADDR_W-1:0] addr;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] gaddr;
  } res_t;

endpackage

// ----- src/ffsa_table.sv -----
module ffsa_table #(
  parameter int unsigned DEPTH = ffsa_pkg::DEF_MAX_SEGMENTS,
  localparam int unsigned IW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  ffsa_pkg::seg_t wdata_i,
  input  logic [IW-1:0] raddr_i,
  output ffsa_pkg::seg_t rdata_o
);

  ffsa_pkg::seg_t mem [DEPTH];
  ffsa_pkg::seg_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/ffsa_seq.sv -----
module ffsa_seq #(
  parameter int unsigned POOL_BYTES   = ffsa_pkg::DEF_POOL_BYTES,
  parameter int unsigned HEADER_BYTES = ffsa_pkg::DEF_HEADER_BYTES,
  parameter int unsigned MAX_SEGMENTS = ffsa_pkg::DEF_MAX_SEGMENTS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  ffsa_pkg::req_t req_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output ffsa_pkg::res_t res_o
);

  localparam int unsigned IW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned LW = ffsa_pkg::LEN_W;
  localparam int unsigned AW = ffsa_pkg::ADDR_W;
  localparam logic [LW-1:0] HDR      = LW'(HEADER_BYTES);
  localparam logic [LW-1:0] POOL_LEN = LW'(POOL_BYTES - HEADER_BYTES);
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_SEGMENTS);

  ffsa_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          act_q, act_d;
  logic [LW-1:0] size_q, size_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [LW:0]   reqh_q, reqh_d;
  logic [IW-1:0] k_q, k_d;
  logic [LW-1:0] pay_q, pay_d;
  logic          prev_used_q, prev_used_d;
  logic [LW-1:0] prev_len_q, prev_len_d;
  logic [IW-1:0] hit_q, hit_d;
  logic [LW-1:0] hlen_q, hlen_d;
  logic          mp_q, mp_d;
  logic          mn_q, mn_d;
  logic [LW-1:0] base_q, base_d;
  logic [LW-1:0] nlen_q, nlen_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic          shv_q, shv_d;
  logic [IW-1:0] wa_q, wa_d;
  logic [1:0]    dist_q, dist_d;
  ffsa_pkg::res_t res_q, res_d;

  logic           we;
  logic [IW-1:0]  waddr;
  ffsa_pkg::seg_t wdata;
  logic [IW-1:0]  raddr;
  ffsa_pkg::seg_t cur;

  // Shared adder: a + b + header, used for offsets and for merged lengths.
  logic [LW-1:0] add_a, add_b, add_sum;
  assign add_sum = add_a + add_b + HDR;

  logic          is_last, alloc_hit, free_hit, do_split, has_next;
  logic [IW-1:0] wi;
  logic [LW-1:0] total;
  logic [1:0]    dsum;

  ffsa_table #(.DEPTH(MAX_SEGMENTS)) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(cur)
  );

  assign is_last   = (CW'(k_q) + CW'(1)) == cnt_q;
  assign alloc_hit = !cur.used && (cur.len >= size_q);
  assign free_hit  = cur.used && (pay_q == {1'b0, addr_q});
  assign do_split  = ({1'b0, cur.len} > reqh_q) && (cnt_q != CNT_MAX);
  assign has_next  = (CW'(hit_q) + CW'(1)) < cnt_q;
  assign wi        = mp_q ? hit_q - IW'(1) : hit_q;
  assign total     = mn_q ? add_sum : base_q;
  assign dsum      = {1'b0, mp_q} + {1'b0, mn_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffsa_pkg::ST_INIT;
      cnt_q   <= CW'(1);
      shv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      shv_q   <= shv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    size_q      <= size_d;
    addr_q      <= addr_d;
    reqh_q      <= reqh_d;
    k_q         <= k_d;
    pay_q       <= pay_d;
    prev_used_q <= prev_used_d;
    prev_len_q  <= prev_len_d;
    hit_q       <= hit_d;
    hlen_q      <= hlen_d;
    mp_q        <= mp_d;
    mn_q        <= mn_d;
    base_q      <= base_d;
    nlen_q      <= nlen_d;
    ptr_q       <= ptr_d;
    wa_q        <= wa_d;
    dist_q      <= dist_d;
    res_q       <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    act_d       = act_q;
    size_d      = size_q;
    addr_d      = addr_q;
    reqh_d      = reqh_q;
    k_d         = k_q;
    pay_d       = pay_q;
    prev_used_d = prev_used_q;
    prev_len_d  = prev_len_q;
    hit_d       = hit_q;
    hlen_d      = hlen_q;
    mp_d        = mp_q;
    mn_d        = mn_q;
    base_d      = base_q;
    nlen_d      = nlen_q;
    ptr_d       = ptr_q;
    shv_d       = shv_q;
    wa_d        = wa_q;
    dist_d      = dist_q;
    res_d       = res_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;
    add_a       = pay_q;
    add_b       = cur.len;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ffsa_pkg::ST_INIT: begin
        we         = 1'b1;
        waddr      = '0;
        wdata.used = 1'b0;
        wdata.len  = POOL_LEN;
        state_d    = ffsa_pkg::ST_IDLE;
      end
      ffsa_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        // Entry 0 is read now so that it is ready in the first scan cycle.
        raddr = '0;
        if (req_valid_i) begin
          act_d       = req_i.action;
          size_d      = req_i.size;
          addr_d      = req_i.addr;
          reqh_d      = {1'b0, req_i.size} + {1'b0, HDR};
          k_d         = '0;
          pay_d       = HDR;
          prev_used_d = 1'b1;
          res_d.gaddr = '0;
          if (!req_i.action && (req_i.size == '0)) begin
            res_d.status = ffsa_pkg::STAT_ZERO;
            state_d      = ffsa_pkg::ST_RESP;
          end else begin
            state_d = ffsa_pkg::ST_SCAN;
          end
        end
      end
      ffsa_pkg::ST_SCAN: begin
        raddr = k_q + IW'(1);
        if (!act_q && alloc_hit) begin
          we           = 1'b1;
          waddr        = k_q;
          wdata.used   = 1'b1;
          wdata.len    = do_split ? size_q : cur.len;
          hit_d        = k_q;
          hlen_d       = cur.len;
          res_d.status = ffsa_pkg::STAT_OK;
          res_d.gaddr  = pay_q[AW-1:0];
          if (do_split) begin
            ptr_d   = cnt_q - CW'(1);
            shv_d   = 1'b0;
            state_d = ffsa_pkg::ST_SHUP;
          end else begin
            state_d = ffsa_pkg::ST_RESP;
          end
        end else if (act_q && free_hit) begin
          hit_d        = k_q;
          hlen_d       = cur.len;
          mp_d         = (k_q != '0) && !prev_used_q;
          res_d.status = ffsa_pkg::STAT_OK;
          state_d      = ffsa_pkg::ST_FNEXT;
        end else if (is_last) begin
          res_d.status = act_q ? ffsa_pkg::STAT_BADFREE : ffsa_pkg::STAT_NOFIT;
          state_d      = ffsa_pkg::ST_RESP;
        end else begin
          k_d         = k_q + IW'(1);
          pay_d       = add_sum;
          prev_used_d = cur.used;
          prev_len_d  = cur.len;
        end
      end
      ffsa_pkg::ST_SHUP: begin
        // Move the entries above the split up by one, top entry first.
        if (shv_q) begin
          we    = 1'b1;
          waddr = wa_q;
          wdata = cur;
        end
        if (ptr_q > CW'(hit_q)) begin
          raddr = ptr_q[IW-1:0];
          wa_d  = ptr_q[IW-1:0] + IW'(1);
          shv_d = 1'b1;
          ptr_d = ptr_q - CW'(1);
        end else begin
          shv_d   = 1'b0;
          state_d = ffsa_pkg::ST_SPLIT;
        end
      end
      ffsa_pkg::ST_SPLIT: begin
        we         = 1'b1;
        waddr      = hit_q + IW'(1);
        wdata.used = 1'b0;
        wdata.len  = LW'({1'b0, hlen_q} - reqh_q);
        cnt_d      = cnt_q + CW'(1);
        state_d    = ffsa_pkg::ST_RESP;
      end
      ffsa_pkg::ST_FNEXT: begin
        // The entry after the freed one is on the read port now.
        add_a   = prev_len_q;
        add_b   = hlen_q;
        base_d  = mp_q ? add_sum : hlen_q;
        mn_d    = has_next && !cur.used;
        nlen_d  = cur.len;
        state_d = ffsa_pkg::ST_FMERGE;
      end
      ffsa_pkg::ST_FMERGE: begin
        add_a      = base_q;
        add_b      = nlen_q;
        we         = 1'b1;
        waddr      = wi;
        wdata.used = 1'b0;
        wdata.len  = total;
        dist_d     = dsum;
        ptr_d      = CW'(wi) + CW'(dsum) + CW'(1);
        shv_d      = 1'b0;
        state_d    = ffsa_pkg::ST_SHDN;
      end
      ffsa_pkg::ST_SHDN: begin
        // Close the gap left by the merged entries, lowest entry first.
        if (shv_q) begin
          we    = 1'b1;
          waddr = wa_q;
          wdata = cur;
        end
        if (ptr_q < cnt_q) begin
          raddr = ptr_q[IW-1:0];
          wa_d  = ptr_q[IW-1:0] - IW'(dist_q);
          shv_d = 1'b1;
          ptr_d = ptr_q + CW'(1);
        end else begin
          shv_d   = 1'b0;
          cnt_d   = cnt_q - CW'(dist_q);
          state_d = ffsa_pkg::ST_RESP;
        end
      end
      ffsa_pkg::ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ffsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ffsa_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  property p_cnt_range;
    @(posedge clk_i) disable iff (!rst_ni)
      (cnt_q != '0) && (cnt_q <= CNT_MAX);
  endproperty
  a_cnt_range: assert property (p_cnt_range) else $error("segment count out of range");

  property p_split_grows;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == ffsa_pkg::ST_SPLIT) |=> (cnt_q == $past(cnt_q) + CW'(1));
  endproperty
  a_split_grows: assert property (p_split_grows) else $error("split did not add an entry");

  property p_idle_no_write;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == ffsa_pkg::ST_IDLE) |-> !we;
  endproperty
  a_idle_no_write: assert property (p_idle_no_write) else $error("table written while idle");

  property p_accept_leaves_idle;
    @(posedge clk_i) disable iff (!rst_ni)
      (req_valid_i && req_ready_o) |=> (state_q != ffsa_pkg::ST_IDLE);
  endproperty
  a_accept_leaves_idle: assert property (p_accept_leaves_idle)
    else $error("request accepted but sequencer stayed idle");

  property p_shift_write_split;
    @(posedge clk_i) disable iff (!rst_ni)
      (we && (state_q == ffsa_pkg::ST_SHUP || state_q == ffsa_pkg::ST_SHDN))
        |-> (waddr != raddr);
  endproperty
  a_shift_write_split: assert property (p_shift_write_split)
    else $error("shift writes the entry it reads");

endmodule

// ----- src/first_fit_segment_allocator.sv -----
// Flow from the input transfer to m_axis_tvalid_o: a zero size allocate goes straight to the
// result; an allocate scans the table up to the entry it takes, a failed scan or a bad free
// scans every entry, an allocate that splits then moves the entries above up and writes the
// new free entry, and a free merges its free neighbours and moves the later entries down.
// Throughput: one request at a time; the next is taken once the result is in the output
// register. Reset clears the control state; table entry 0 is then written before any request.
module first_fit_segment_allocator #(
  parameter int unsigned POOL_BYTES   = ffsa_pkg::DEF_POOL_BYTES,
  parameter int unsigned HEADER_BYTES = ffsa_pkg::DEF_HEADER_BYTES,
  parameter int unsigned MAX_SEGMENTS = ffsa_pkg::DEF_MAX_SEGMENTS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // request_size [20:0], address [40:21], zero fill above
  input  logic [ffsa_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // action: 0 allocate, 1 free
  input  logic                             s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // status [1:0], granted_address [21:2], zero fill above
  output logic [ffsa_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned LW = ffsa_pkg::LEN_W;
  localparam int unsigned AW = ffsa_pkg::ADDR_W;

  ffsa_pkg::req_t req;
  ffsa_pkg::res_t res;
  logic           res_valid;
  logic           res_ready;
  logic           out_valid_q, out_valid_d;
  ffsa_pkg::res_t out_q;

  assign req.action = s_axis_tuser_i;
  assign req.size   = s_axis_tdata_i[LW-1:0];
  assign req.addr   = s_axis_tdata_i[LW+AW-1:LW];

  ffsa_seq #(
    .POOL_BYTES  (POOL_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid_i),
    .req_ready_o(s_axis_tready_o),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // The output register frees the sequencer as soon as a result is parked.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = ffsa_pkg::OUT_TDATA_W'({out_q.gaddr, out_q.status});

endmodule

// ----- dv/tb.sv -----
module tb;

  localparam int unsigned POOL   = ffsa_pkg::DEF_POOL_BYTES;
  localparam int unsigned HDR    = ffsa_pkg::DEF_HEADER_BYTES;
  localparam int unsigned MAXSEG = ffsa_pkg::DEF_MAX_SEGMENTS;
  localparam int unsigned LW     = ffsa_pkg::LEN_W;
  localparam int unsigned AW     = ffsa_pkg::ADDR_W;
  localparam int unsigned IDW    = ffsa_pkg::IN_TDATA_W;
  localparam int unsigned ODW    = ffsa_pkg::OUT_TDATA_W;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam int N_RANDOM   = 1930;
  localparam int CALM_TAIL  = 150;
  localparam int DRAIN_WAIT = 400;
  localparam int LIMIT      = 2000000;

  typedef struct {
    ffsa_pkg::req_t rq;
    bit             hold;
  } job_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           s_valid = 1'b0;
  logic           s_ready;
  logic [IDW-1:0] s_tdata = '0;
  logic           s_tuser = 1'b0;
  logic           m_valid;
  logic           m_ready = 1'b0;
  logic [ODW-1:0] m_tdata;

  // Shadow copy of the segment table.
  logic [AW-1:0] seg_base [MAXSEG];
  logic [LW-1:0] seg_len  [MAXSEG];
  logic          seg_busy [MAXSEG];
  int unsigned   seg_cnt;

  job_t           pending[$];
  ffsa_pkg::res_t due_results[$];
  logic [AW-1:0]  live_addrs[$];

  int  n_accepted = 0;
  int  n_checked = 0;
  int  errors = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  cycles = 0;
  bit  calm = 1'b0;

  first_fit_segment_allocator uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Applies one request to the shadow table and returns the result the block owes.
  function automatic ffsa_pkg::res_t pool_apply(ffsa_pkg::req_t rq);
    ffsa_pkg::res_t rs;
    int unsigned    i;
    int unsigned    j;
    int unsigned    need;
    rs.status = ffsa_pkg::STAT_OK;
    rs.gaddr  = '0;
    if (rq.action == ACT_ALLOC) begin
      need = 32'(rq.size);
      if (need == 0) begin
        rs.status = ffsa_pkg::STAT_ZERO;
      end else begin
        i = 0;
        while (i < seg_cnt && (seg_busy[i] || seg_len[i] < need)) i++;
        if (i == seg_cnt) begin
          rs.status = ffsa_pkg::STAT_NOFIT;
        end else begin
          // A split needs room for one more header and a free table slot.
          if (seg_len[i] > need + HDR && seg_cnt < MAXSEG) begin
            for (j = seg_cnt - 1; j > i; j--) begin
              seg_base[j+1] = seg_base[j];
              seg_len[j+1]  = seg_len[j];
              seg_busy[j+1] = seg_busy[j];
            end
            seg_base[i+1] = AW'(seg_base[i] + HDR + need);
            seg_len[i+1]  = LW'(seg_len[i] - need - HDR);
            seg_busy[i+1] = 1'b0;
            seg_len[i]    = LW'(need);
            seg_cnt++;
          end
          seg_busy[i] = 1'b1;
          rs.gaddr = AW'(seg_base[i] + HDR);
          live_addrs.push_back(rs.gaddr);
        end
      end
    end else begin
      i = 0;
      while (i < seg_cnt && !(seg_busy[i] && seg_base[i] + HDR == rq.addr)) i++;
      if (i == seg_cnt) begin
        rs.status = ffsa_pkg::STAT_BADFREE;
      end else begin
        seg_busy[i] = 1'b0;
        i = 0;
        while (i + 1 < seg_cnt) begin
          if (!seg_busy[i] && !seg_busy[i+1]) begin
            seg_len[i] = LW'(seg_len[i] + HDR + seg_len[i+1]);
            for (j = i + 1; j + 1 < seg_cnt; j++) begin
              seg_base[j] = seg_base[j+1];
              seg_len[j]  = seg_len[j+1];
              seg_busy[j] = seg_busy[j+1];
            end
            seg_cnt--;
          end else begin
            i++;
          end
        end
        for (j = 0; j < live_addrs.size(); j++) begin
          if (live_addrs[j] == rq.addr) begin
            live_addrs.delete(j);
            break;
          end
        end
      end
    end
    return rs;
  endfunction

  task automatic queue_job(logic action, int unsigned size, int unsigned addr, bit hold);
    job_t jb;
    jb.rq.action = action;
    jb.rq.size   = LW'(size);
    jb.rq.addr   = AW'(addr);
    jb.hold      = hold;
    pending.push_back(jb);
  endtask

  // Sender: a hold item waits until every earlier transfer has its result back.
  always @(posedge clk_i) begin : sender
    job_t           jb;
    logic [IDW-1:0] word;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || s_ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_valid  <= 1'b0;
      end else if (pending.size() != 0 && (!pending[0].hold ||
                   (n_accepted == n_checked && !(s_valid && s_ready)))) begin
        jb = pending.pop_front();
        word = '0;
        word[LW-1:0]  = jb.rq.size;
        word[LW+:AW]  = jb.rq.addr;
        s_tdata <= word;
        s_tuser <= jb.rq.action;
        s_valid <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 9);
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : receiver
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_ready    <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 8);
      m_ready    <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : monitor
    ffsa_pkg::req_t rq;
    ffsa_pkg::res_t want;
    logic [1:0]     got_status;
    logic [AW-1:0]  got_gaddr;
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        rq.action = s_tuser;
        rq.size   = s_tdata[LW-1:0];
        rq.addr   = s_tdata[LW+:AW];
        due_results.push_back(pool_apply(rq));
        n_accepted <= n_accepted + 1;
      end
      if (m_valid && m_ready) begin
        got_status = m_tdata[1:0];
        got_gaddr  = m_tdata[2+:AW];
        if (due_results.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected result, expected none, got status %0d addr %0d",
                   $time, got_status, got_gaddr);
        end else begin
          want = due_results.pop_front();
          n_checked <= n_checked + 1;
          if (got_status != want.status || got_gaddr != want.gaddr) begin
            errors <= errors + 1;
            $display("%0t: mismatch, expected status %0d addr %0d, got status %0d addr %0d",
                     $time, want.status, want.gaddr, got_status, got_gaddr);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned size;
    int unsigned addr;
    int          phase;
    int          pick;
    logic        action;
    bit          hold;
    for (int k = 0; k < MAXSEG; k++) begin
      seg_base[k] = '0;
      seg_len[k]  = '0;
      seg_busy[k] = 1'b0;
    end
    seg_len[0] = LW'(POOL - HDR);
    seg_cnt    = 1;

    // Directed part: odd sizes, whole pool grants, exact and near fits, bad frees.
    queue_job(ACT_ALLOC, 0, 0, 1'b0);
    queue_job(ACT_ALLOC, 2097151, 1048575, 1'b0);
    queue_job(ACT_ALLOC, POOL, 0, 1'b0);
    queue_job(ACT_ALLOC, POOL - HDR, 0, 1'b0);
    queue_job(ACT_ALLOC, 1, 0, 1'b0);
    queue_job(ACT_FREE, 2097151, HDR, 1'b0);
    queue_job(ACT_FREE, 0, HDR, 1'b0);
    queue_job(ACT_FREE, 0, 1048575, 1'b0);
    queue_job(ACT_FREE, 0, 0, 1'b0);
    queue_job(ACT_ALLOC, POOL - 2 * HDR, 0, 1'b0);
    queue_job(ACT_FREE, 0, HDR, 1'b0);
    // Leaves a one byte tail whose payload sits at the top address.
    queue_job(ACT_ALLOC, POOL - 2 * HDR - 1, 0, 1'b0);
    queue_job(ACT_ALLOC, 1, 0, 1'b0);
    queue_job(ACT_FREE, 0, 1048575, 1'b0);
    queue_job(ACT_FREE, 0, HDR, 1'b0);
    queue_job(ACT_ALLOC, 100, 0, 1'b0);
    queue_job(ACT_ALLOC, 200, 0, 1'b0);
    queue_job(ACT_ALLOC, 300, 0, 1'b0);
    queue_job(ACT_FREE, 0, HDR + 100 + HDR, 1'b0);
    queue_job(ACT_ALLOC, 150, 0, 1'b0);
    queue_job(ACT_FREE, 0, 1048575, 1'b0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int n = 0; n < N_RANDOM; n++) begin
      while (pending.size() >= 2) @(negedge clk_i);
      calm  = (n >= N_RANDOM - CALM_TAIL) || ((n / 90) % 4 == 3);
      hold  = (n % DRAIN_WAIT == 0);
      phase = (n / 120) % 3;
      pick  = $urandom_range(0, 99);
      // Fill phases push the table to full, drain phases coalesce it back.
      if (phase == 0) action = (pick < 80) ? ACT_ALLOC : ACT_FREE;
      else if (phase == 1) action = (pick < 20) ? ACT_ALLOC : ACT_FREE;
      else action = (pick < 50) ? ACT_ALLOC : ACT_FREE;
      pick = $urandom_range(0, 99);
      size = 0;
      addr = $urandom_range(0, 1048575);
      if (action == ACT_ALLOC) begin
        size = $urandom_range(0, 2097151);
        if (pick < 4) size = 0;
        else if (pick < 8) size = $urandom_range(0, 2097151);
        else if (pick < 60) size = $urandom_range(1, 64);
        else if (pick < 85) size = $urandom_range(1, 4096);
        else if (pick < 95) size = $urandom_range(1, 65536);
        else size = $urandom_range(1, POOL);
      end else begin
        if (live_addrs.size() != 0 && pick < 85)
          addr = 32'(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
        else if (pick >= 92)
          addr = HDR + $urandom_range(0, 4096);
        size = $urandom_range(0, 2097151);
      end
      queue_job(action, size, addr, hold);
    end

    while (pending.size() != 0 || s_valid) @(posedge clk_i);
    while (n_accepted != n_checked) @(posedge clk_i);
    repeat (4 * MAXSEG + 50) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/ffsa_pkg.sv
src/ffsa_table.sv
src/ffsa_seq.sv
src/first_fit_segment_allocator.sv
dv/tb.sv
